// ===== rtl/base64_stream_encoder_top_macros.svh =====
// Assertion macros used by the encoder back end.
`ifndef BASE64_STREAM_ENCODER_TOP_MACROS_SVH
`define BASE64_STREAM_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define B64_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("encoder assertion failed");

// Next-cycle implication, disabled during reset.
`define B64_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("encoder assertion failed");

`endif

// ===== rtl/b64enc_pkg.sv =====
// Package with the group type, constants and alphabet lookup of the Base64 encoder.
`default_nettype none
package b64enc_pkg;

    localparam int B64_QUEUE_DEPTH = 2;
    localparam logic [7:0] B64_PAD = 8'h3D;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] n;
        logic       last;
    } t_group;

    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] x;
        logic [7:0] c;
        x = {2'b00, idx};
        if (idx < 6'd26) begin
            c = 8'(8'd65 + x);
        end else if (idx < 6'd52) begin
            c = 8'(8'd71 + x);
        end else if (idx < 6'd62) begin
            c = 8'(x - 8'd4);
        end else if (idx == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/b64enc_front.sv =====
// Front end: accepts bytes, gathers groups of up to three and hands them to the queue.
`default_nettype none
module b64enc_front
    import b64enc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,
    input  wire logic       i_s_tlast,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_group          o_group
);

    logic [7:0] r_held0;
    logic [7:0] r_held1;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       accept;
    logic       flush;

    assign o_s_tready = !i_q_full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign flush      = (r_count == 2'd2) || i_s_tlast;
    assign o_push     = accept && flush;

    always_comb begin
        o_group.b0   = (r_count == 2'd0) ? i_s_tdata : r_held0;
        o_group.b1   = (r_count == 2'd2) ? r_held1 :
                       ((r_count == 2'd1) ? i_s_tdata : 8'h00);
        o_group.b2   = (r_count == 2'd2) ? i_s_tdata : 8'h00;
        o_group.n    = 2'(r_count + 2'd1);
        o_group.last = i_s_tlast;
    end

    always_comb begin
        n_count = r_count;
        if (accept) begin
            n_count = flush ? 2'd0 : 2'(r_count + 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !flush) begin
            if (r_count == 2'd0) begin
                r_held0 <= i_s_tdata;
            end else begin
                r_held1 <= i_s_tdata;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/b64enc_queue.sv =====
// Short queue of byte groups between the front and back ends.
`default_nettype none
module b64enc_queue
    import b64enc_pkg::*;
#(
    parameter int DEPTH = B64_QUEUE_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_group i_group,
    output logic        o_full,
    output logic        o_valid,
    input  wire logic   i_pop,
    output t_group      o_group
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_group             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_group = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/b64enc_back.sv =====
// Back end: splits a group into four characters and drives the output register.
`default_nettype none
`include "base64_stream_encoder_top_macros.svh"
module b64enc_back
    import b64enc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_valid,
    input  wire t_group i_group,
    output logic        o_pop,
    output logic        o_m_tvalid,
    input  wire logic   i_m_tready,
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast,
    output logic        o_m_tuser
);

    t_group     r_grp;
    logic       r_busy;
    logic [1:0] r_k;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_run_last;
    logic       r_msg_end;
    logic       emit;
    logic [5:0] idx;
    logic       pad;
    logic [7:0] chr;

    assign emit  = r_busy && (!r_out_valid || i_m_tready);
    assign o_pop = i_q_valid && (!r_busy || (emit && (r_k == 2'd3)));

    always_comb begin
        case (r_k)
            2'd0:    idx = r_grp.b0[7:2];
            2'd1:    idx = {r_grp.b0[1:0], r_grp.b1[7:4]};
            2'd2:    idx = {r_grp.b1[3:0], r_grp.b2[7:6]};
            default: idx = r_grp.b2[5:0];
        endcase
        pad = (r_grp.n != 2'd3) && (r_k > r_grp.n);
        chr = pad ? B64_PAD : b64_char(idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_k         <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && (r_k == 2'd3)) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_k <= 2'(r_k + 2'd1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_group;
        end
        if (emit) begin
            r_out_char <= chr;
            r_run_last <= (r_k == 2'd3);
            r_msg_end  <= (r_k == 2'd3) && r_grp.last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_msg_end;
    assign o_m_tuser  = r_run_last;

    `B64_ASSERT_IMPL(a_idle_index_zero, i_clk, i_rst_n, !r_busy, r_k == 2'd0)
    `B64_ASSERT_NEXT(a_fourth_ends_run, i_clk, i_rst_n, emit && (r_k == 2'd3),
                     r_out_valid && r_run_last)
    `B64_ASSERT_IMPL(a_end_is_run_end, i_clk, i_rst_n, r_out_valid && r_msg_end, r_run_last)

endmodule
`default_nettype wire

// ===== rtl/base64_stream_encoder_top.sv =====
// A group's completing byte goes into the queue, then the group register, then the output register.
// Throughput: one character per cycle while i_m_tready is high; each group gives four characters.
// Bytes are taken every cycle while the group queue has room; the character sequencer sets the rate.
// Reset is synchronous, active low, and clears the byte count, queue and output valid.
// The held bytes are not cleared and are only read after being written.
`default_nettype none
module base64_stream_encoder_top
    import b64enc_pkg::*;
#(
    parameter int QUEUE_DEPTH = B64_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // in_byte[7:0]
    input  wire logic       i_s_tlast,
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // out_char[7:0]
    output logic            o_m_tlast,
    output logic            o_m_tuser    // run_last[0]
);

    t_group push_grp;
    t_group pop_grp;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_valid;

    b64enc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_group    (push_grp)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (push_grp),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_group (pop_grp)
    );

    b64enc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_group    (pop_grp),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
`default_nettype wire

// ===== dv/base64_stream_encoder_top_tb.sv =====
// Self-checking testbench of the Base64 stream encoder, driving directed and random messages.
module base64_stream_encoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import b64enc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_BYTES = 138;
    localparam int RESET_CYCLES = 6;
    localparam bit [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0]  in_byte;
        logic        msg_last;
        logic        has_chars;
        logic [31:0] chars;
    } t_row;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       msg_end;
    } t_char;

    localparam int DIRECTED_COUNT = 22;
    localparam t_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{8'h4D, 1'b1, 1'b1, "TQ=="},
        '{8'h4D, 1'b0, 1'b0, 32'h0},
        '{8'h61, 1'b1, 1'b1, "TWE="},
        '{8'h4D, 1'b0, 1'b0, 32'h0},
        '{8'h61, 1'b0, 1'b0, 32'h0},
        '{8'h6E, 1'b0, 1'b1, "TWFu"},
        '{8'h00, 1'b0, 1'b0, 32'h0},
        '{8'h00, 1'b0, 1'b0, 32'h0},
        '{8'h00, 1'b1, 1'b1, "AAAA"},
        '{8'hFF, 1'b0, 1'b0, 32'h0},
        '{8'hFF, 1'b0, 1'b0, 32'h0},
        '{8'hFF, 1'b0, 1'b1, "////"},
        '{8'hFB, 1'b0, 1'b0, 32'h0},
        '{8'hEF, 1'b0, 1'b0, 32'h0},
        '{8'hBE, 1'b1, 1'b1, "++++"},
        '{8'hFF, 1'b1, 1'b1, "/w=="},
        '{8'h00, 1'b0, 1'b0, 32'h0},
        '{8'hFF, 1'b1, 1'b0, 32'h0},
        '{8'hA5, 1'b0, 1'b0, 32'h0},
        '{8'h5A, 1'b0, 1'b0, 32'h0},
        '{8'hC3, 1'b0, 1'b0, 32'h0},
        '{8'h3C, 1'b1, 1'b0, 32'h0}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = 8'h00;  // in_byte[7:0]
    logic       i_s_tlast = 1'b0;
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;          // out_char[7:0]
    logic       o_m_tlast;
    logic       o_m_tuser;          // run_last[0]

    t_char       expected_chars[$];
    logic [7:0]  held_bytes [2];
    int unsigned held_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    base64_stream_encoder_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [7:0] index_char(input logic [5:0] idx);
        return ALPHABET[8*(63-int'(idx)) +: 8];
    endfunction

    task automatic encode_byte(input t_row row);
        logic [7:0]  grp [3];
        logic [5:0]  idx [4];
        t_char       c;
        int unsigned n;
        int unsigned real_chars;
        grp[0] = 8'h00;
        grp[1] = 8'h00;
        grp[2] = 8'h00;
        for (int k = 0; k < int'(held_count); k++) begin
            grp[k] = held_bytes[k];
        end
        grp[held_count] = row.in_byte;
        n = held_count + 1;
        if (n < 3 && !row.msg_last) begin
            held_bytes[n-1] = row.in_byte;
            held_count = n;
            return;
        end
        idx[0] = grp[0][7:2];
        idx[1] = {grp[0][1:0], grp[1][7:4]};
        idx[2] = {grp[1][3:0], grp[2][7:6]};
        idx[3] = grp[2][5:0];
        real_chars = (n == 3) ? 4 : n + 1;
        for (int k = 0; k < 4; k++) begin
            if (row.has_chars) begin
                c.out_char = row.chars[8*(3-k) +: 8];
            end else begin
                c.out_char = (k < int'(real_chars)) ? index_char(idx[k]) : B64_PAD;
            end
            c.run_last = (k == 3);
            c.msg_end = (k == 3) && row.msg_last;
            expected_chars.push_back(c);
        end
        held_count = 0;
    endtask

    task automatic send_byte(input t_row row);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= row.in_byte;
        i_s_tlast <= row.msg_last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        encode_byte(row);
    endtask

    always @(posedge i_clk) begin
        t_char want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected word: out_char %h", o_m_tdata);
                error_count++;
            end else begin
                want = expected_chars.pop_front();
                if (o_m_tdata !== want.out_char) begin
                    $error("out_char: expected %h, actual %h", want.out_char, o_m_tdata);
                    error_count++;
                end
                if (o_m_tuser !== want.run_last) begin
                    $error("run_last: expected %b, actual %b", want.run_last, o_m_tuser);
                    error_count++;
                end
                if (o_m_tlast !== want.msg_end) begin
                    $error("msg_end: expected %b, actual %b", want.msg_end, o_m_tlast);
                    error_count++;
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_row        row;
        int unsigned sent;
        int unsigned msg_len;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 30;
        recv_idle_pct = 87;
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            send_byte(DIRECTED_ROWS[i]);
        end

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            if (sent < RANDOM_BYTES / 3) begin
                send_idle_pct = 30;
                recv_idle_pct = 87;
            end else if (sent < 2 * RANDOM_BYTES / 3) begin
                send_idle_pct = 87;
                recv_idle_pct = 30;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            msg_len = ($urandom_range(9) == 0) ? $urandom_range(24, 10) : $urandom_range(7, 1);
            for (int unsigned j = 0; j < msg_len; j++) begin
                row.in_byte = 8'($urandom_range(255));
                row.msg_last = (j == msg_len - 1);
                row.has_chars = 1'b0;
                row.chars = 32'h0;
                send_byte(row);
                sent++;
            end
        end
        i_s_tvalid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_chars.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
